// File: rtl/ncsk_pkg.sv
package ncsk_pkg;

    // Internal fixed point: signed Q7.24 in 32 bits
    localparam int FIX_W = 32;
    localparam int FRAC_W = 24;
    localparam logic signed [63:0] FIX_ONE = 64'sd16777216;
    localparam logic signed [63:0] INT32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] INT32_MIN = -64'sd2147483648;
    localparam int POS_W = 25;
    localparam int OUT_W = 18;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    // Reciprocal of 6 scaled by 2^37, rounded up; exact floor for inputs below 2^35
    localparam logic [34:0] DIV6_MAGIC = 35'd22906492246;

    typedef logic signed [FIX_W-1:0] fix_t;

    // Divider request and response between sequencer and divider
    typedef struct packed {
        logic              start;
        logic signed [63:0] num;
        logic signed [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] quo;
    } div_rsp_t;

    // Saturate a wide value to 32 bits
    function automatic fix_t sat32(input logic signed [63:0] v);
        fix_t r;
        if (v > INT32_MAX)
            r = fix_t'(INT32_MAX[31:0]);
        else if (v < INT32_MIN)
            r = fix_t'(INT32_MIN[31:0]);
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/natural_cubic_spline_kernel_unit.sv
// With a table that matches taps, an item runs check, read, three multiply-adds
// on one shared multiplier and output, then the result strobe.
// A taps change first runs a rebuild, mostly 6*taps-2 divides on the shared serial divider.
// No new item is taken before the result strobe; busy is high until the strobe.
// Reset: asynchronous active low; taps returns to 4, no table is built; no stall.
module natural_cubic_spline_kernel_unit
#(
    parameter int MAX_TAPS = 128
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [24:0]        position,
    output logic                      done,
    output logic signed [17:0]        kernel_value,
    output logic                      in_support,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [7:0]                cfg_data
);

    localparam int NW = $clog2(2 * MAX_TAPS + 1);
    localparam int TW = $clog2(4 * MAX_TAPS);
    localparam int PW = (2 * MAX_TAPS > 1) ? $clog2(2 * MAX_TAPS) : 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_W     = 5'd2;
    localparam logic [4:0] S_WW    = 5'd3;
    localparam logic [4:0] S_Z     = 5'd4;
    localparam logic [4:0] S_ZW    = 5'd5;
    localparam logic [4:0] S_MRD   = 5'd6;
    localparam logic [4:0] S_M     = 5'd7;
    localparam logic [4:0] S_MW    = 5'd8;
    localparam logic [4:0] S_CRD0  = 5'd9;
    localparam logic [4:0] S_CRD1  = 5'd10;
    localparam logic [4:0] S_CA    = 5'd11;
    localparam logic [4:0] S_CAW   = 5'd12;
    localparam logic [4:0] S_CB    = 5'd13;
    localparam logic [4:0] S_CC    = 5'd14;
    localparam logic [4:0] S_CCW   = 5'd15;
    localparam logic [4:0] S_ERD   = 5'd16;
    localparam logic [4:0] S_EMUL  = 5'd17;
    localparam logic [4:0] S_EADD  = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;
    localparam logic [4:0] S_CA2   = 5'd20;
    localparam logic [4:0] S_CC2   = 5'd21;

    logic [4:0]  state_reg;
    logic [7:0]  taps_reg;
    logic [7:0]  built_reg;
    logic [8:0]  j_reg;
    logic [1:0]  k_reg;
    logic [TW-1:0] base_reg;
    logic [15:0] r_reg;
    logic        inside_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    ncsk_pkg::fix_t w_prev_reg;
    ncsk_pkg::fix_t z_prev_reg;
    ncsk_pkg::fix_t m_next_reg;
    ncsk_pkg::fix_t m0_reg;
    ncsk_pkg::fix_t m1_reg;
    ncsk_pkg::fix_t rd_tab_reg;
    ncsk_pkg::fix_t rd_piv_reg;
    ncsk_pkg::fix_t rd_fwd_reg;
    ncsk_pkg::fix_t rd_mom_reg;
    logic        done_reg;
    logic signed [17:0] kv_reg;
    logic        sup_reg;
    logic [33:0] d6_un_reg;
    logic        d6_neg_reg;
    logic [51:0] d6_lo_reg;

    ncsk_pkg::fix_t coef_mem [4*MAX_TAPS];
    ncsk_pkg::fix_t piv_mem [2*MAX_TAPS];
    ncsk_pkg::fix_t fwd_mem [2*MAX_TAPS];
    ncsk_pkg::fix_t mom_mem [2*MAX_TAPS+1];

    ncsk_pkg::div_req_t dreq;
    ncsk_pkg::div_rsp_t drsp;

    logic [8:0]  teff;
    logic [8:0]  n2;
    logic signed [63:0] rhs;
    logic [24:0] mag;
    logic signed [63:0] rnd16;
    logic signed [63:0] rnd8;
    logic signed [63:0] v_sat;
    logic signed [63:0] d6_n;
    logic signed [63:0] d6_abs;
    logic [33:0] d6_mag;
    logic [16:0] d6_op;
    logic [51:0] d6_mul;
    logic [68:0] d6_sum;
    logic signed [63:0] d6_res;

    // Effective taps
    always_comb
    begin
        if (taps_reg == 8'd0)
            teff = 9'd1;
        else if ({1'b0, taps_reg} > 9'(MAX_TAPS))
            teff = 9'(MAX_TAPS);
        else
            teff = {1'b0, taps_reg};
        n2 = {teff[7:0], 1'b0};
    end

    // Right-hand side of the moment system at row j
    always_comb
    begin
        if (j_reg == teff - 9'd1)
            rhs = -12 * ncsk_pkg::FIX_ONE;
        else if (teff > 9'd1 && (j_reg == teff - 9'd2 || j_reg == teff))
            rhs = 6 * ncsk_pkg::FIX_ONE;
        else
            rhs = '0;
    end

    assign mag = position[24] ? 25'(-position) : 25'(position);

    // Rounded shifts of the Horner product and final result
    always_comb
    begin
        rnd16 = prod_reg[63] ? -((-prod_reg + 64'sd32768) >>> 16)
                             : ((prod_reg + 64'sd32768) >>> 16);
        rnd8 = acc_reg[63] ? -((-acc_reg + 64'sd128) >>> 8)
                           : ((acc_reg + 64'sd128) >>> 8);
        if (rnd8 > 64'sd131071)
            v_sat = 64'sd131071;
        else if (rnd8 < -64'sd131072)
            v_sat = -64'sd131072;
        else
            v_sat = rnd8;
    end

    // Rounded divide by 6 through a reciprocal multiply, low then high half
    always_comb
    begin
        if (state_reg == S_CA)
            d6_n = 64'(rd_mom_reg) - 64'(m0_reg);
        else
            d6_n = 64'(m1_reg) + 2 * 64'(m0_reg);
        d6_abs = d6_n[63] ? -d6_n : d6_n;
        d6_mag = d6_abs[33:0] + 34'd3;
        d6_op = (state_reg == S_CAW || state_reg == S_CCW) ? d6_un_reg[16:0]
                                                           : d6_un_reg[33:17];
        d6_mul = {35'd0, d6_op} * {17'd0, ncsk_pkg::DIV6_MAGIC};
        d6_sum = {d6_mul, 17'd0} + {17'd0, d6_lo_reg};
        d6_res = d6_neg_reg ? (64'sd0 - $signed({32'd0, d6_sum[68:37]}))
                            : $signed({32'd0, d6_sum[68:37]});
    end

    // Divider requests from the rebuild sequencer
    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num = '0;
        dreq.den = 33'sd6;
        case (state_reg)
            S_W:
            begin
                dreq.start = (j_reg != 9'd0);
                dreq.num = ncsk_pkg::FIX_ONE * ncsk_pkg::FIX_ONE;
                dreq.den = 33'(w_prev_reg);
            end
            S_Z:
            begin
                dreq.start = 1'b1;
                dreq.num = (rhs - 64'(z_prev_reg)) * ncsk_pkg::FIX_ONE;
                dreq.den = 33'(w_prev_reg);
            end
            S_M:
            begin
                dreq.start = 1'b1;
                dreq.num = 64'(m_next_reg) * ncsk_pkg::FIX_ONE;
                dreq.den = 33'(rd_piv_reg);
            end
            default:
            begin
                dreq.start = 1'b0;
            end
        endcase
    end

    ncsk_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Registered memory reads
    always_ff @(posedge clk)
    begin
        rd_tab_reg <= coef_mem[base_reg + TW'(k_reg)];
        rd_piv_reg <= piv_mem[PW'(j_reg - 9'd1)];
        rd_fwd_reg <= fwd_mem[PW'(j_reg - 9'd1)];
        rd_mom_reg <= mom_mem[NW'(j_reg)];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            taps_reg <= 8'd4;
            built_reg <= 8'd0;
            done_reg <= 1'b0;
            kv_reg <= '0;
            sup_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                taps_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        inside_reg <= ({16'd0, mag[24:16]} < {16'd0, teff});
                        base_reg <= TW'({mag[24:16], 2'b00});
                        r_reg <= mag[15:0];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    j_reg <= '0;
                    if ({1'b0, built_reg} != teff)
                    begin
                        w_prev_reg <= ncsk_pkg::fix_t'(32'sd67108864);
                        state_reg <= S_W;
                    end
                    else
                    begin
                        k_reg <= 2'd0;
                        state_reg <= S_ERD;
                    end
                end
                S_W:
                begin
                    if (j_reg == 9'd0)
                    begin
                        piv_mem[0] <= w_prev_reg;
                        z_prev_reg <= '0;
                        state_reg <= S_Z;
                    end
                    else
                        state_reg <= S_WW;
                end
                S_WW:
                begin
                    if (drsp.done)
                    begin
                        w_prev_reg <= ncsk_pkg::sat32(4 * ncsk_pkg::FIX_ONE - drsp.quo);
                        piv_mem[PW'(j_reg)] <=
                            ncsk_pkg::sat32(4 * ncsk_pkg::FIX_ONE - drsp.quo);
                        state_reg <= S_Z;
                    end
                end
                S_Z:
                begin
                    state_reg <= S_ZW;
                end
                S_ZW:
                begin
                    if (drsp.done)
                    begin
                        z_prev_reg <= ncsk_pkg::sat32(drsp.quo);
                        fwd_mem[PW'(j_reg)] <= ncsk_pkg::sat32(drsp.quo);
                        if (j_reg == n2 - 9'd1)
                        begin
                            mom_mem[NW'(n2)] <= '0;
                            m_next_reg <= '0;
                            j_reg <= n2 - 9'd1;
                            state_reg <= S_MRD;
                        end
                        else
                        begin
                            j_reg <= j_reg + 9'd1;
                            state_reg <= S_W;
                        end
                    end
                end
                S_MRD:
                begin
                    if (j_reg == 9'd0)
                    begin
                        j_reg <= teff;
                        state_reg <= S_CRD0;
                    end
                    else
                        state_reg <= S_M;
                end
                S_M:
                begin
                    state_reg <= S_MW;
                end
                S_MW:
                begin
                    if (drsp.done)
                    begin
                        m_next_reg <= ncsk_pkg::sat32(64'(rd_fwd_reg) - drsp.quo);
                        mom_mem[NW'(j_reg)] <= ncsk_pkg::sat32(64'(rd_fwd_reg) - drsp.quo);
                        j_reg <= j_reg - 9'd1;
                        state_reg <= S_MRD;
                    end
                end
                S_CRD0:
                begin
                    j_reg <= j_reg + 9'd1;
                    state_reg <= S_CRD1;
                end
                S_CRD1:
                begin
                    m0_reg <= rd_mom_reg;
                    j_reg <= j_reg - 9'd1;
                    state_reg <= S_CA;
                end
                S_CA:
                begin
                    m1_reg <= rd_mom_reg;
                    d6_un_reg <= d6_mag;
                    d6_neg_reg <= d6_n[63];
                    state_reg <= S_CAW;
                end
                S_CAW:
                begin
                    d6_lo_reg <= d6_mul;
                    state_reg <= S_CA2;
                end
                S_CA2:
                begin
                    coef_mem[TW'({j_reg - teff, 2'b00})] <= ncsk_pkg::sat32(d6_res);
                    state_reg <= S_CB;
                end
                S_CB:
                begin
                    coef_mem[TW'({j_reg - teff, 2'b01})] <= ncsk_pkg::sat32(
                        m0_reg[31] ? -((-64'(m0_reg) + 64'sd1) >>> 1)
                                   : ((64'(m0_reg) + 64'sd1) >>> 1));
                    state_reg <= S_CC;
                end
                S_CC:
                begin
                    d6_un_reg <= d6_mag;
                    d6_neg_reg <= d6_n[63];
                    coef_mem[TW'({j_reg - teff, 2'b11})] <=
                        (j_reg == teff) ? ncsk_pkg::fix_t'(32'sd16777216) : '0;
                    state_reg <= S_CCW;
                end
                S_CCW:
                begin
                    d6_lo_reg <= d6_mul;
                    state_reg <= S_CC2;
                end
                S_CC2:
                begin
                    coef_mem[TW'({j_reg - teff, 2'b10})] <= ncsk_pkg::sat32(
                        ((j_reg == teff) ? -ncsk_pkg::FIX_ONE : 64'sd0) - d6_res);
                    if (j_reg == n2 - 9'd1)
                    begin
                        built_reg <= teff[7:0];
                        k_reg <= 2'd0;
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        j_reg <= j_reg + 9'd1;
                        state_reg <= S_CRD0;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EMUL;
                end
                S_EMUL:
                begin
                    if (k_reg == 2'd0)
                        acc_reg <= 64'(rd_tab_reg);
                    else
                        acc_reg <= rnd16 + 64'(rd_tab_reg);
                    if (k_reg == 2'd3)
                        state_reg <= S_OUT;
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                        state_reg <= S_EADD;
                    end
                end
                S_EADD:
                begin
                    prod_reg <= acc_reg * $signed({1'b0, r_reg});
                    state_reg <= S_EMUL;
                end
                S_OUT:
                begin
                    kv_reg <= inside_reg ? v_sat[17:0] : '0;
                    sup_reg <= inside_reg;
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign done = done_reg;
    assign kernel_value = kv_reg;
    assign in_support = sup_reg;

endmodule

// File: rtl/ncsk_div.sv
// Restoring divider, one quotient bit per cycle, round to nearest with ties
// away from zero. Divide by zero gives zero.
module ncsk_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  ncsk_pkg::div_req_t req,
    output ncsk_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [63:0] un;
    logic [63:0] ud;
    logic [64:0] trial;
    logic [63:0] q_signed;

    // Magnitudes with half the divisor added for rounding
    always_comb
    begin
        ud = req.den[32] ? 64'(-req.den) : 64'(req.den);
        un = req.num[63] ? (64'd0 - req.num) : req.num;
        un = un + (ud >> 1);
        trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        q_signed = neg_reg ? (64'd0 - quo_reg) : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= (ud == 64'd0) ? 64'd0 : un;
            den_reg <= (ud == 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : ud;
            neg_reg <= req.num[63] ^ req.den[32];
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo = q_signed;

endmodule

// File: rtl/ncsk_checker.sv
module ncsk_props
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic signed [17:0] kernel_value,
    input logic              in_support
);

    // Accepting an item raises busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after transfer");

    // The result strobe drops busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy high with result strobe");

    // Outside the support the value is zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_support) |-> (kernel_value == 18'sd0))
        else $error("nonzero value outside support");

    // Strobe lasts one cycle
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind natural_cubic_spline_kernel_unit ncsk_props u_ncsk_props
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .kernel_value (kernel_value),
    .in_support   (in_support)
);
